>>> rtl/sfir_pkg.sv
// shared types and constants for the stereo fir filter core
package sfir_pkg;

    localparam int DATA_W     = 16;
    localparam int NUM_COEF   = 8;
    localparam int HIST_DEPTH = 8;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int TAPS_DEF   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = 2 * DATA_W;
    // eight q2.30 products need 35 bits
    localparam int ACC_W      = PROD_W + $clog2(NUM_COEF);
    localparam int FRAC_W     = DATA_W - 1;
    localparam int Q_W        = ACC_W + 1 - FRAC_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } t_state;

endpackage

>>> rtl/stereo_fir_filter_core.sv
// stereo fir filter core: one multiply-accumulate unit per channel stepped over the taps
// an accepted word passes the mac sweep, the drain state and the round state, which waits for a free output register
// a new word is taken only after the last result is loaded, the per-channel mac stepping one tap a cycle
// the input is taken again while a finished result still waits in the output register
// reset (synchronous, active low) clears coefficients, both delay lines and all control state
// config writes are always taken; an index beyond the coefficient list is ignored
module stereo_fir_filter_core #(
    parameter int TAPS = sfir_pkg::TAPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [sfir_pkg::DATA_W-1:0]             i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [sfir_pkg::DATA_W-1:0]      i_left_in,
    input  logic signed [sfir_pkg::DATA_W-1:0]      i_right_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [sfir_pkg::DATA_W-1:0]      o_left_out,
    output logic signed [sfir_pkg::DATA_W-1:0]      o_right_out,
    output logic                                    o_left_clipped,
    output logic                                    o_right_clipped
);

    localparam int DW     = sfir_pkg::DATA_W;
    localparam int PW     = sfir_pkg::PROD_W;
    localparam int AW     = sfir_pkg::ACC_W;
    localparam int QW     = sfir_pkg::Q_W;
    localparam int FW     = sfir_pkg::FRAC_W;
    localparam int HD     = sfir_pkg::HIST_DEPTH;
    localparam int HIW    = sfir_pkg::HIST_IDX_W;
    localparam int NC     = sfir_pkg::NUM_COEF;
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);
    localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (DW - 1)) - 1);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (DW - 1));
    localparam logic signed [DW-1:0] D_MAX = DW'((1 << (DW - 1)) - 1);
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    sfir_pkg::t_state r_state, n_state;

    logic signed [DW-1:0] r_coef  [NC];
    logic signed [DW-1:0] r_hist_l[HD];
    logic signed [DW-1:0] r_hist_r[HD];

    logic [TAP_W-1:0]     r_tap;
    logic signed [PW-1:0] r_prod_l, r_prod_r;
    logic                 r_prod_valid;
    logic signed [AW-1:0] r_acc_l, r_acc_r;

    logic w_accept, w_issue, w_load_out, w_out_free;
    logic [HIW-1:0] w_idx;

    logic signed [AW:0]   w_rnd_l, w_rnd_r;
    logic signed [QW-1:0] w_q_l, w_q_r;
    logic signed [DW-1:0] w_sat_l, w_sat_r;
    logic                 w_clip_l, w_clip_r;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_out_free  = ~o_out_valid | i_out_ready;
    assign w_idx       = HIW'(r_tap);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfir_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sfir_pkg::ST_MAC;
            end
            sfir_pkg::ST_MAC: begin
                if (r_tap == TAP_LAST) n_state = sfir_pkg::ST_DRAIN;
            end
            sfir_pkg::ST_DRAIN: begin
                n_state = sfir_pkg::ST_ROUND;
            end
            sfir_pkg::ST_ROUND: begin
                if (w_out_free) n_state = sfir_pkg::ST_IDLE;
            end
            default: begin
                n_state = sfir_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            sfir_pkg::ST_IDLE:  o_in_ready = 1'b1;
            sfir_pkg::ST_MAC:   w_issue    = 1'b1;
            sfir_pkg::ST_DRAIN: o_in_ready = 1'b0;
            sfir_pkg::ST_ROUND: w_load_out = w_out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfir_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NC; k++) r_coef[k] <= '0;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index < sfir_pkg::CFG_IDX_W'(NC))) begin
            r_coef[HIW'(i_cfg_index)] <= i_cfg_data;
        end
    end

    // newest-first delay lines, all entries shift on every word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HD; k++) begin
                r_hist_l[k] <= '0;
                r_hist_r[k] <= '0;
            end
        end else if (w_accept) begin
            for (int k = HD - 1; k > 0; k--) begin
                r_hist_l[k] <= r_hist_l[k-1];
                r_hist_r[k] <= r_hist_r[k-1];
            end
            r_hist_l[0] <= i_left_in;
            r_hist_r[0] <= i_right_in;
        end
    end

    // mac: product registered, summed in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap        <= '0;
            r_prod_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_tap <= '0;
            end else if (w_issue && r_tap != TAP_LAST) begin
                r_tap <= r_tap + 1'b1;
            end
            r_prod_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_prod_l <= r_coef[w_idx] * r_hist_l[w_idx];
            r_prod_r <= r_coef[w_idx] * r_hist_r[w_idx];
        end
        if (w_accept) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_prod_valid) begin
            r_acc_l <= r_acc_l + {{(AW-PW){r_prod_l[PW-1]}}, r_prod_l};
            r_acc_r <= r_acc_r + {{(AW-PW){r_prod_r[PW-1]}}, r_prod_r};
        end
    end

    // round half up to q1.15, then saturate
    always_comb begin
        w_rnd_l = {r_acc_l[AW-1], r_acc_l} + (AW+1)'(1 << (FW - 1));
        w_rnd_r = {r_acc_r[AW-1], r_acc_r} + (AW+1)'(1 << (FW - 1));
        w_q_l   = w_rnd_l[AW:FW];
        w_q_r   = w_rnd_r[AW:FW];
        w_clip_l = 1'b1;
        w_clip_r = 1'b1;
        if (w_q_l > Q_MAX)      w_sat_l = D_MAX;
        else if (w_q_l < Q_MIN) w_sat_l = D_MIN;
        else begin
            w_sat_l  = w_q_l[DW-1:0];
            w_clip_l = 1'b0;
        end
        if (w_q_r > Q_MAX)      w_sat_r = D_MAX;
        else if (w_q_r < Q_MIN) w_sat_r = D_MIN;
        else begin
            w_sat_r  = w_q_r[DW-1:0];
            w_clip_r = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_left_out      <= w_sat_l;
            o_right_out     <= w_sat_r;
            o_left_clipped  <= w_clip_l;
            o_right_clipped <= w_clip_r;
        end
    end

    a_idle_no_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_prod_valid)
        else $error("product pending while accepting a new word");

    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == sfir_pkg::ST_MAC) && (r_tap == '0))
        else $error("accepted word did not start the mac sweep");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap <= TAP_LAST)
        else $error("tap counter past last tap");

    a_clip_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_left_clipped) |-> (o_left_out == D_MAX || o_left_out == D_MIN))
        else $error("left clip flag without a saturated value");

endmodule
